// ===== design/hs3_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// hs3_pkg: shared types and constants of the Horn hillshade block
// Command and status types between controller and datapath, sizes of the
// fixed-point datapath, register indexes and their reset values.
// ============================================================================
package hs3_pkg;

    // datapath operation codes
    localparam logic [3:0] OP_NONE = 4'd0;
    localparam logic [3:0] OP_LOAD = 4'd1;   // take input word, store or set up shade
    localparam logic [3:0] OP_RD   = 4'd2;   // read one neighbor sample
    localparam logic [3:0] OP_MUL  = 4'd3;   // one product of numerator or radicand
    localparam logic [3:0] OP_SQI  = 4'd4;   // start square root
    localparam logic [3:0] OP_SQ   = 4'd5;   // one root digit
    localparam logic [3:0] OP_DVI  = 4'd6;   // start division
    localparam logic [3:0] OP_DV   = 4'd7;   // one quotient bit
    localparam logic [3:0] OP_OUT  = 4'd8;   // saturate and load output word

    typedef struct packed {
        logic [3:0] op;
        logic [2:0] idx;
    } t_cmd;

    typedef struct packed {
        logic shade_go;   // input word is a shade inside the image
        logic out_free;   // output register can take a word
    } t_stat;

    // register indexes
    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_CELL   = 3'd2;
    localparam logic [2:0] REG_COSZ   = 3'd3;
    localparam logic [2:0] REG_SUNX   = 3'd4;
    localparam logic [2:0] REG_SUNY   = 3'd5;

    localparam logic [8:0]  RST_WIDTH  = 9'd256;
    localparam logic [8:0]  RST_HEIGHT = 9'd256;
    localparam logic [15:0] RST_CELL   = 16'd256;
    localparam logic [14:0] RST_COSZ   = 15'd11585;
    localparam logic [15:0] RST_SUNX   = 16'hE000;
    localparam logic [15:0] RST_SUNY   = 16'd8192;

    // datapath widths
    localparam int NW   = 19;   // Horn sums
    localparam int MW   = 20;   // multiplier operands
    localparam int PW   = 40;   // product
    localparam int TW   = 44;   // numerator T
    localparam int QW   = 56;   // radicand
    localparam int SW   = 28;   // root
    localparam int NUMW = 45;   // dividend / quotient

    // sequencer last counts
    localparam logic [5:0] LAST_RD  = 6'd7;
    localparam logic [5:0] LAST_MUL = 6'd5;
    localparam logic [5:0] LAST_SQ  = 6'(QW / 2 - 1);
    localparam logic [5:0] LAST_DV  = 6'(NUMW - 1);

endpackage

// ===== design/hillshade_3x3_frame.sv =====
`timescale 1ns / 1ps
// ============================================================================
// hillshade_3x3_frame: elevation frame store with per-pixel Horn hillshade
// Top level: sequencer plus datapath around one single-port frame memory.
// ============================================================================
// Use:
//   Slave stream carries commands. tuser[0] is the command: low stores the
//   elevation sample at (row, col), high asks for the shade of that pixel.
//   A store completes in the accept cycle and frees the port at once; a shade
//   outside the image in use is dropped without a result.
//   Master stream returns one word per shade: shade (Q1.15), row, column.
//   Configuration channel writes image width, height, cell size, cos zenith,
//   sun x and sun y by index; it is always ready. The user must see that it is
//   written only while idle; the block itself does not enforce this.
// Sequence:
//   A shade runs through 8 reads of the single memory port plus drain,
//   6 products on the shared multiplier plus drain, the bit-pair square root,
//   the bit-serial divider and the output load. One shade is in flight at a
//   time, so a new command is taken the cycle after the result is loaded.
// Reset and stall:
//   Synchronous active-low reset clears the sequencer, the output valid and
//   restores register defaults; frame contents stay undefined until written.
//   A stalled result holds in the output register while the next command is
//   accepted; a finished shade waits in its last step until that word leaves.
// ============================================================================
module hillshade_3x3_frame #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,    // row[7:0], col[15:8], elevation[31:16]
    input  logic [0:0]  i_s_tuser,    // command[0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,    // shade[15:0], out_row[23:16], out_col[31:24]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    hs3_pkg::t_cmd  cmd;
    hs3_pkg::t_stat stat;

    // registers always take a write
    assign o_cfg_ready = 1'b1;

    hs3_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    hs3_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid & o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );
endmodule

// ===== design/hs3_ram.sv =====
`timescale 1ns / 1ps
// ============================================================================
// hs3_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ============================================================================
module hs3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/hs3_ctrl.sv =====
`timescale 1ns / 1ps
// ============================================================================
// hs3_ctrl: shade sequencer
// Steps the datapath through neighbor reads, products, root and division.
// ============================================================================
module hs3_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  hs3_pkg::t_stat i_stat,
    output hs3_pkg::t_cmd  o_cmd
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_READ = 4'd1;
    localparam logic [3:0] S_RDRN = 4'd2;
    localparam logic [3:0] S_MUL  = 4'd3;
    localparam logic [3:0] S_MDRN = 4'd4;
    localparam logic [3:0] S_SQI  = 4'd5;
    localparam logic [3:0] S_SQ   = 4'd6;
    localparam logic [3:0] S_DVI  = 4'd7;
    localparam logic [3:0] S_DV   = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    logic [3:0] r_state, n_state;
    logic [5:0] r_cnt, n_cnt;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd.op   = hs3_pkg::OP_NONE;
        o_cmd.idx  = r_cnt[2:0];
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.op = hs3_pkg::OP_LOAD;
                    if (i_stat.shade_go) begin
                        n_state = S_READ;
                        n_cnt   = '0;
                    end
                end
            end
            S_READ: begin
                o_cmd.op = hs3_pkg::OP_RD;
                n_cnt    = r_cnt + 6'd1;
                if (r_cnt == hs3_pkg::LAST_RD) n_state = S_RDRN;
            end
            S_RDRN: begin
                n_state = S_MUL;
                n_cnt   = '0;
            end
            S_MUL: begin
                o_cmd.op = hs3_pkg::OP_MUL;
                n_cnt    = r_cnt + 6'd1;
                if (r_cnt == hs3_pkg::LAST_MUL) n_state = S_MDRN;
            end
            S_MDRN: n_state = S_SQI;
            S_SQI: begin
                o_cmd.op = hs3_pkg::OP_SQI;
                n_state  = S_SQ;
                n_cnt    = '0;
            end
            S_SQ: begin
                o_cmd.op = hs3_pkg::OP_SQ;
                n_cnt    = r_cnt + 6'd1;
                if (r_cnt == hs3_pkg::LAST_SQ) n_state = S_DVI;
            end
            S_DVI: begin
                o_cmd.op = hs3_pkg::OP_DVI;
                n_state  = S_DV;
                n_cnt    = '0;
            end
            S_DV: begin
                o_cmd.op = hs3_pkg::OP_DV;
                n_cnt    = r_cnt + 6'd1;
                if (r_cnt == hs3_pkg::LAST_DV) n_state = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = hs3_pkg::OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end
endmodule

// ===== design/hs3_dp.sv =====
`timescale 1ns / 1ps
// ============================================================================
// hs3_dp: hillshade datapath
// Configuration registers, frame memory, Horn sums, shared multiplier,
// bit-serial square root and divider, output register.
// ============================================================================
module hs3_dp #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  hs3_pkg::t_cmd  i_cmd,
    output hs3_pkg::t_stat o_stat,
    input  logic [31:0]   i_s_tdata,
    input  logic [0:0]    i_s_tuser,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [31:0]   o_m_tdata,
    input  logic          i_cfg_valid,
    input  logic [2:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_data
);
    localparam int WCW  = $clog2(MAX_WIDTH + 1);
    localparam int HCW  = $clog2(MAX_HEIGHT + 1);
    localparam int CCW  = (WCW > 9) ? WCW : 9;
    localparam int CHW  = (HCW > 9) ? HCW : 9;
    localparam int CIW  = $clog2(MAX_WIDTH);
    localparam int HIW  = $clog2(MAX_HEIGHT);
    localparam int AW   = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int NW   = hs3_pkg::NW;
    localparam int MW   = hs3_pkg::MW;
    localparam int PW   = hs3_pkg::PW;
    localparam int TW   = hs3_pkg::TW;
    localparam int QW   = hs3_pkg::QW;
    localparam int SW   = hs3_pkg::SW;
    localparam int NUMW = hs3_pkg::NUMW;

    // configuration
    logic [8:0]  r_img_w, r_img_h;
    logic [15:0] r_cell, r_sunx, r_suny;
    logic [14:0] r_cosz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= hs3_pkg::RST_WIDTH;
            r_img_h <= hs3_pkg::RST_HEIGHT;
            r_cell  <= hs3_pkg::RST_CELL;
            r_cosz  <= hs3_pkg::RST_COSZ;
            r_sunx  <= hs3_pkg::RST_SUNX;
            r_suny  <= hs3_pkg::RST_SUNY;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                hs3_pkg::REG_WIDTH:  r_img_w <= i_cfg_data[8:0];
                hs3_pkg::REG_HEIGHT: r_img_h <= i_cfg_data[8:0];
                hs3_pkg::REG_CELL:   r_cell  <= i_cfg_data;
                hs3_pkg::REG_COSZ:   r_cosz  <= i_cfg_data[14:0];
                hs3_pkg::REG_SUNX:   r_sunx  <= i_cfg_data;
                hs3_pkg::REG_SUNY:   r_suny  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective dimensions and input decode
    logic [CCW-1:0] w_cfg, w_eff, in_col;
    logic [CHW-1:0] h_cfg, h_eff, in_row;
    logic           in_frame, in_img, is_shade;
    logic [HIW-1:0] up_n, dn_n;
    logic [CIW-1:0] lf_n, rt_n;

    assign w_cfg  = CCW'(r_img_w);
    assign h_cfg  = CHW'(r_img_h);
    assign w_eff  = (w_cfg == '0) ? CCW'(1) :
                    (w_cfg > CCW'(MAX_WIDTH)) ? CCW'(MAX_WIDTH) : w_cfg;
    assign h_eff  = (h_cfg == '0) ? CHW'(1) :
                    (h_cfg > CHW'(MAX_HEIGHT)) ? CHW'(MAX_HEIGHT) : h_cfg;
    assign in_row = CHW'(i_s_tdata[7:0]);
    assign in_col = CCW'(i_s_tdata[15:8]);
    assign is_shade = i_s_tuser[0];
    assign in_frame = (in_row < CHW'(MAX_HEIGHT)) && (in_col < CCW'(MAX_WIDTH));
    assign in_img   = (in_row < h_eff) && (in_col < w_eff);
    assign up_n = HIW'((in_row == '0) ? h_eff - CHW'(1) : in_row - CHW'(1));
    assign dn_n = HIW'((in_row + CHW'(1) == h_eff) ? '0 : in_row + CHW'(1));
    assign lf_n = CIW'((in_col == '0) ? w_eff - CCW'(1) : in_col - CCW'(1));
    assign rt_n = CIW'((in_col + CCW'(1) == w_eff) ? '0 : in_col + CCW'(1));

    assign o_stat.shade_go = is_shade && in_img;

    logic [HIW-1:0] r_up, r_dn, r_rw;
    logic [CIW-1:0] r_lf, r_rt, r_cl;
    logic [7:0]     r_orow, r_ocol;

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == hs3_pkg::OP_LOAD) begin
            r_up   <= up_n;
            r_dn   <= dn_n;
            r_rw   <= HIW'(in_row);
            r_lf   <= lf_n;
            r_rt   <= rt_n;
            r_cl   <= CIW'(in_col);
            r_orow <= i_s_tdata[7:0];
            r_ocol <= i_s_tdata[15:8];
        end
    end

    // frame memory
    logic [HIW-1:0] rd_r;
    logic [CIW-1:0] rd_c;
    logic [AW-1:0]  ram_addr;
    logic           ram_we;
    logic [15:0]    ram_rdata;

    always_comb begin
        unique case (i_cmd.idx)
            3'd0: begin rd_r = r_dn; rd_c = r_lf; end
            3'd1: begin rd_r = r_dn; rd_c = r_cl; end
            3'd2: begin rd_r = r_dn; rd_c = r_rt; end
            3'd3: begin rd_r = r_rw; rd_c = r_lf; end
            3'd4: begin rd_r = r_rw; rd_c = r_rt; end
            3'd5: begin rd_r = r_up; rd_c = r_lf; end
            3'd6: begin rd_r = r_up; rd_c = r_cl; end
            3'd7: begin rd_r = r_up; rd_c = r_rt; end
            default: begin rd_r = r_rw; rd_c = r_cl; end
        endcase
    end

    assign ram_we   = (i_cmd.op == hs3_pkg::OP_LOAD) && !is_shade && in_frame;
    assign ram_addr = (i_cmd.op == hs3_pkg::OP_LOAD)
                    ? AW'(AW'(in_row) * AW'(MAX_WIDTH) + AW'(in_col))
                    : AW'(AW'(rd_r) * AW'(MAX_WIDTH) + AW'(rd_c));

    hs3_ram #(
        .WIDTH (16),
        .DEPTH (MAX_WIDTH * MAX_HEIGHT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_s_tdata[31:16]),
        .o_rdata (ram_rdata)
    );

    // Horn sums: accumulate each sample the cycle after its read
    logic                 r_rd_vld;
    logic [2:0]           r_rd_idx;
    logic signed [NW-1:0] r_nx, r_ny, z1, z2;

    assign z1 = signed'(NW'(ram_rdata));
    assign z2 = signed'(NW'({ram_rdata, 1'b0}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= (i_cmd.op == hs3_pkg::OP_RD);
        end
        r_rd_idx <= i_cmd.idx;
        if (i_cmd.op == hs3_pkg::OP_LOAD) begin
            r_nx <= '0;
            r_ny <= '0;
        end else if (r_rd_vld) begin
            unique case (r_rd_idx)
                3'd0: begin r_nx <= r_nx - z1; r_ny <= r_ny - z1; end
                3'd1: r_ny <= r_ny - z2;
                3'd2: begin r_nx <= r_nx + z1; r_ny <= r_ny - z1; end
                3'd3: r_nx <= r_nx - z2;
                3'd4: r_nx <= r_nx + z2;
                3'd5: begin r_nx <= r_nx - z1; r_ny <= r_ny + z1; end
                3'd6: r_ny <= r_ny + z2;
                3'd7: begin r_nx <= r_nx + z1; r_ny <= r_ny + z1; end
                default: ;
            endcase
        end
    end

    // shared multiplier, product registered then accumulated
    logic [15:0]          cs_eff;
    logic signed [MW-1:0] ma, mb;
    logic signed [PW-1:0] r_prod;
    logic                 r_pr_vld;
    logic [2:0]           r_pr_sel;
    logic signed [TW-1:0] r_t, prod_t;
    logic [QW-1:0]        r_q;

    assign cs_eff = (r_cell == '0) ? 16'd1 : r_cell;

    always_comb begin
        unique case (i_cmd.idx)
            3'd0: begin ma = signed'(MW'(r_cosz)); mb = signed'(MW'(cs_eff)); end
            3'd1: begin ma = MW'(signed'(r_sunx)); mb = MW'(r_nx); end
            3'd2: begin ma = MW'(signed'(r_suny)); mb = MW'(r_ny); end
            3'd3: begin ma = signed'(MW'(cs_eff)); mb = signed'(MW'(cs_eff)); end
            3'd4: begin ma = MW'(r_nx); mb = MW'(r_nx); end
            3'd5: begin ma = MW'(r_ny); mb = MW'(r_ny); end
            default: begin ma = '0; mb = '0; end
        endcase
    end

    assign prod_t = TW'(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pr_vld <= 1'b0;
        end else begin
            r_pr_vld <= (i_cmd.op == hs3_pkg::OP_MUL);
        end
        r_pr_sel <= i_cmd.idx;
        r_prod   <= ma * mb;
        if (i_cmd.op == hs3_pkg::OP_LOAD) begin
            r_t <= '0;
            r_q <= '0;
        end else if (r_pr_vld) begin
            unique case (r_pr_sel)
                3'd0: r_t <= r_t + (prod_t <<< 11);
                3'd1: r_t <= r_t - prod_t;
                3'd2: r_t <= r_t + prod_t;
                3'd3: r_q <= r_q + (QW'(r_prod[PW-2:0]) << 22);
                3'd4, 3'd5: r_q <= r_q + QW'(r_prod[PW-2:0]);
                default: ;
            endcase
        end
    end

    // square root, two radicand bits per step
    logic [QW-1:0]   r_rad;
    logic [SW:0]     r_srem;
    logic [SW-1:0]   r_root;
    logic [SW+2:0]   sq_sh, sq_trial;

    assign sq_sh    = {r_srem, r_rad[QW-1:QW-2]};
    assign sq_trial = {1'b0, r_root, 2'b01};

    // division, one quotient bit per step; quotient shifts into r_num
    logic [NUMW-1:0] r_num;
    logic [SW-1:0]   r_drem;
    logic            r_neg;
    logic [SW:0]     dv_sh;
    logic [TW-1:0]   t_abs;

    assign dv_sh = {r_drem, r_num[NUMW-1]};
    assign t_abs = r_t[TW-1] ? TW'(-r_t) : TW'(r_t);

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            hs3_pkg::OP_SQI: begin
                r_rad  <= r_q;
                r_srem <= '0;
                r_root <= '0;
            end
            hs3_pkg::OP_SQ: begin
                r_rad <= r_rad << 2;
                if (sq_sh >= sq_trial) begin
                    r_srem <= (SW + 1)'(sq_sh - sq_trial);
                    r_root <= {r_root[SW-2:0], 1'b1};
                end else begin
                    r_srem <= (SW + 1)'(sq_sh);
                    r_root <= {r_root[SW-2:0], 1'b0};
                end
            end
            hs3_pkg::OP_DVI: begin
                r_num  <= NUMW'({t_abs, 1'b0}) + NUMW'(r_root >> 1);
                r_drem <= '0;
                r_neg  <= r_t[TW-1];
            end
            hs3_pkg::OP_DV: begin
                if (dv_sh >= {1'b0, r_root}) begin
                    r_drem <= SW'(dv_sh - {1'b0, r_root});
                    r_num  <= {r_num[NUMW-2:0], 1'b1};
                end else begin
                    r_drem <= SW'(dv_sh);
                    r_num  <= {r_num[NUMW-2:0], 1'b0};
                end
            end
            default: ;
        endcase
    end

    // saturate and hold the result word
    logic [15:0] shade_n;
    logic        r_mvalid;
    logic [31:0] r_mdata;

    always_comb begin
        if (r_neg) begin
            shade_n = (r_num > NUMW'(32768)) ? 16'h8000 : 16'(16'd0 - r_num[15:0]);
        end else begin
            shade_n = (r_num > NUMW'(32767)) ? 16'h7FFF : r_num[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
        end else if (i_cmd.op == hs3_pkg::OP_OUT) begin
            r_mvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_mvalid <= 1'b0;
        end
        if (i_cmd.op == hs3_pkg::OP_OUT) begin
            r_mdata <= {r_ocol, r_orow, shade_n};
        end
    end

    assign o_stat.out_free = !r_mvalid || i_m_tready;
    assign o_m_tvalid      = r_mvalid;
    assign o_m_tdata       = r_mdata;
endmodule

// ===== design/hs3_chk.sv =====
`timescale 1ns / 1ps
// ============================================================================
// hs3_chk: port-level checks of the hillshade block
// Watches the streams and flags sequencing slips.
// ============================================================================
module hs3_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [0:0]  i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata
);
    // stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("output word changed under stall");

    // a result only appears while a shade is in flight
    a_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(!o_s_tready))
        else $error("result without shade in flight");

    // a store never blocks the next command
    a_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && !i_s_tuser[0] |=> o_s_tready)
        else $error("store stalled the input");

    // reset drops output valid
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");
endmodule

bind hillshade_3x3_frame hs3_chk u_chk (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_top: self-checking bench for the Horn hillshade frame block
// Feeds store and shade words on the input stream. Before each shade, stores
// every sample of its 3x3 window so that no unwritten entry is ever read.
// Works out each shade in an integer model of the Horn gradient, square root
// and rounded division, and checks the result words in order. Steps through
// several register settings, including the extremes and out-of-range values,
// with random gaps and stalls on both streams.
// ============================================================================
module tb_top;

    localparam logic [2:0] REG_SPARE_A = 3'd6;   // unmapped indexes, writes are dropped
    localparam logic [2:0] REG_SPARE_B = 3'd7;
    localparam int         CYCLE_LIMIT = 2_000_000;
    localparam bit         CMD_STORE   = 1'b0;
    localparam bit         CMD_SHADE   = 1'b1;

    typedef struct {
        bit        cmd;
        bit [7:0]  row;
        bit [7:0]  col;
        bit [15:0] elev;
    } dem_word_t;

    typedef struct {
        bit [15:0] shade;
        bit [7:0]  row;
        bit [7:0]  col;
    } shade_word_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    hillshade_3x3_frame i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Register copies, updated on each configuration handshake
    bit [8:0]  img_w;
    bit [8:0]  img_h;
    bit [15:0] cell_sz;
    bit [14:0] cosz;
    bit [15:0] sunx;
    bit [15:0] suny;

    logic [15:0] elev_mem [65536];   // samples as the block holds them
    bit          planned  [65536];   // entries that queued stores will have written

    dem_word_t   pending_words[$];
    shade_word_t expected_shades[$];
    dem_word_t   in_flight;
    int          send_gap;
    int          results_seen;
    int          errors;
    bit          no_idle;            // burst mode: no gaps, no stalls
    bit          long_hold_done;
    int          hold_cnt;
    int          cycles;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int eff_dim(bit [8:0] v);
        if (v == 0) return 1;
        if (v > 256) return 256;
        return v;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint pix(int r, int c);
        return longint'(elev_mem[r * 256 + c]);
    endfunction

    // Apply one accepted word: store the sample, or queue the expected shade
    function automatic void take_word(dem_word_t wd);
        int              w, h, up, dn, lf, rt;
        longint          nx, ny, dd, t;
        longint unsigned q, s, mag, res;
        shade_word_t     e;
        if (wd.cmd == CMD_STORE) begin
            elev_mem[wd.row * 256 + wd.col] = wd.elev;
            return;
        end
        w = eff_dim(img_w);
        h = eff_dim(img_h);
        if (wd.row >= h || wd.col >= w) return;   // outside image: no word
        up = (wd.row + h - 1) % h;
        dn = (wd.row + 1) % h;
        lf = (wd.col + w - 1) % w;
        rt = (wd.col + 1) % w;
        nx = (pix(dn, rt) + 2 * pix(wd.row, rt) + pix(up, rt))
           - (pix(dn, lf) + 2 * pix(wd.row, lf) + pix(up, lf));
        ny = (pix(up, lf) + 2 * pix(up, wd.col) + pix(up, rt))
           - (pix(dn, lf) + 2 * pix(dn, wd.col) + pix(dn, rt));
        dd = 2048 * longint'((cell_sz == 0) ? 16'd1 : cell_sz);
        t  = longint'(cosz) * dd - longint'($signed(sunx)) * nx
           + longint'($signed(suny)) * ny;
        q  = dd * dd + nx * nx + ny * ny;
        s  = root_floor(q);
        mag = (t < 0) ? -t : t;
        res = (2 * mag + s / 2) / s;
        if (t < 0) e.shade = (res > 32768) ? 16'h8000 : 16'(-longint'(res));
        else       e.shade = (res > 32767) ? 16'h7fff : 16'(res);
        e.row = wd.row;
        e.col = wd.col;
        expected_shades.insert(expected_shades.size(), e);
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Input driver: hold the word until taken, then advance to the next
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_tvalid && s_tready) take_word(in_flight);
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    in_flight = pending_words.pop_front();
                    s_tdata  <= {in_flight.elev, in_flight.col, in_flight.row};
                    s_tuser  <= in_flight.cmd;
                    s_tvalid <= 1'b1;
                    send_gap = pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output ready: random stalls, plus one long hold-off to back up the block
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            hold_cnt = 0;
        end else if (hold_cnt > 0) begin
            hold_cnt = hold_cnt - 1;
            m_tready <= 1'b0;
        end else if (!long_hold_done && results_seen >= 30) begin
            long_hold_done = 1'b1;
            hold_cnt = 2500;
            m_tready <= 1'b0;
        end else begin
            m_tready <= no_idle ? 1'b1 : (pick_gap() == 0);
        end
    end

    // Result monitor: compare each word with the oldest expected shade
    always @(posedge i_clk) begin
        shade_word_t e;
        if (i_rst_n && m_tvalid && m_tready) begin
            results_seen = results_seen + 1;
            if (expected_shades.size() == 0) begin
                $error("unexpected result word %h", m_tdata);
                errors = errors + 1;
            end else begin
                e = expected_shades.pop_front();
                if (m_tdata[15:0] !== e.shade) begin
                    $error("shade: expected %0d, got %0d",
                           $signed(e.shade), $signed(m_tdata[15:0]));
                    errors = errors + 1;
                end
                if (m_tdata[23:16] !== e.row) begin
                    $error("out_row: expected %0d, got %0d", e.row, m_tdata[23:16]);
                    errors = errors + 1;
                end
                if (m_tdata[31:24] !== e.col) begin
                    $error("out_col: expected %0d, got %0d", e.col, m_tdata[31:24]);
                    errors = errors + 1;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        forever begin
            @(posedge i_clk);
            if (cfg_ready) break;
        end
        unique case (idx)
            hs3_pkg::REG_WIDTH:  img_w   = val[8:0];
            hs3_pkg::REG_HEIGHT: img_h   = val[8:0];
            hs3_pkg::REG_CELL:   cell_sz = val;
            hs3_pkg::REG_COSZ:   cosz    = val[14:0];
            hs3_pkg::REG_SUNX:   sunx    = val;
            hs3_pkg::REG_SUNY:   suny    = val;
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(int w, int h, int cs, int cz, int sx, int sy);
        write_reg(hs3_pkg::REG_WIDTH, 16'(w));
        write_reg(hs3_pkg::REG_HEIGHT, 16'(h));
        write_reg(hs3_pkg::REG_CELL, 16'(cs));
        write_reg(hs3_pkg::REG_COSZ, 16'(cz));
        write_reg(hs3_pkg::REG_SUNX, 16'(sx));
        write_reg(hs3_pkg::REG_SUNY, 16'(sy));
    endtask

    function automatic void queue_store(int r, int c, int e);
        dem_word_t wd;
        wd.cmd  = CMD_STORE;
        wd.row  = 8'(r);
        wd.col  = 8'(c);
        wd.elev = 16'(e);
        planned[r * 256 + c] = 1'b1;
        pending_words.insert(pending_words.size(), wd);
    endfunction

    function automatic int rand_elev(bit rough);
        return rough ? $urandom_range(0, 65535) : 30000 + $urandom_range(0, 400);
    endfunction

    // Queue a shade; first fill any unwritten sample of its window
    function automatic void queue_shade(int r, int c, bit rough);
        dem_word_t wd;
        int        w, h, rr, cc;
        w = eff_dim(img_w);
        h = eff_dim(img_h);
        if (r < h && c < w) begin
            for (int dr = -1; dr <= 1; dr++) begin
                for (int dc = -1; dc <= 1; dc++) begin
                    rr = (r + h + dr) % h;
                    cc = (c + w + dc) % w;
                    if (!planned[rr * 256 + cc]) queue_store(rr, cc, rand_elev(rough));
                end
            end
        end
        wd.cmd  = CMD_SHADE;
        wd.row  = 8'(r);
        wd.col  = 8'(c);
        wd.elev = 16'($urandom_range(0, 65535));   // unused by a shade
        pending_words.insert(pending_words.size(), wd);
    endfunction

    // Drain: wait until every word is taken and every shade has come back
    task automatic drain();
        do @(posedge i_clk);
        while (pending_words.size() > 0 || s_tvalid || expected_shades.size() > 0);
        repeat (120) @(posedge i_clk);   // let a trailing shade finish
    endtask

    task automatic random_phase(int n, bit rough);
        int w, h, k;
        w = eff_dim(img_w);
        h = eff_dim(img_h);
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            if (k < 25)
                queue_store($urandom_range(0, 255), $urandom_range(0, 255),
                            rand_elev(rough));
            else if (k < 90)
                queue_shade($urandom_range(0, h - 1), $urandom_range(0, w - 1), rough);
            else
                queue_shade($urandom_range(0, 255), $urandom_range(0, 255), rough);
        end
        drain();
    endtask

    initial begin
        i_rst_n   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        img_w   = hs3_pkg::RST_WIDTH;
        img_h   = hs3_pkg::RST_HEIGHT;
        cell_sz = hs3_pkg::RST_CELL;
        cosz    = hs3_pkg::RST_COSZ;
        sunx    = hs3_pkg::RST_SUNX;
        suny    = hs3_pkg::RST_SUNY;
        errors = 0;
        results_seen = 0;
        cycles = 0;
        no_idle = 1'b0;
        long_hold_done = 1'b0;
        foreach (planned[i]) planned[i] = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: extreme samples and the corner pixels with wrap
        queue_store(0, 0, 16'hffff);
        queue_store(255, 255, 0);
        queue_store(0, 255, 16'hffff);
        queue_store(255, 0, 0);
        queue_shade(0, 0, 1'b1);
        queue_shade(255, 255, 1'b1);
        queue_shade(0, 255, 1'b1);
        queue_shade(128, 127, 1'b0);
        drain();

        // Single-pixel frame, strongest sun and smallest cell
        set_regs(1, 1, 1, 16384, 16384, -16384);
        write_reg(REG_SPARE_A, 16'hffff);
        write_reg(REG_SPARE_B, 16'h1234);
        queue_shade(0, 0, 1'b1);
        queue_shade(0, 1, 1'b1);    // outside image
        queue_shade(5, 0, 1'b1);    // outside image
        drain();

        // Two-by-three frame, largest cell, sun from the other side
        set_regs(2, 3, 65535, 0, -16384, 16384);
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 2; c++) queue_shade(r, c, 1'b1);
        queue_shade(3, 0, 1'b1);
        queue_shade(0, 2, 1'b1);
        drain();

        // Out-of-range dimensions and zero cell size; long receiver hold-off
        set_regs(0, 511, 0, 16384, -16384, -16384);
        random_phase(80, 1'b1);

        // Full frame, no idling
        no_idle = 1'b1;
        set_regs(256, 256, 256, 11585, -8192, 8192);
        random_phase(40, 1'b1);
        no_idle = 1'b0;

        for (int p = 0; p < 7; p++) begin
            set_regs($urandom_range(1, 20), $urandom_range(1, 20),
                     $urandom_range(1, 65535), $urandom_range(0, 16384),
                     $urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384);
            random_phase(120, p[0]);
        end

        if (errors == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

endmodule
